// ===== rtl/sts_pkg.sv =====
// Shared types, tag table and tag classifier for the style tag stripper.
package sts_pkg;

    localparam int NUM_TAGS  = 8;
    localparam int WIN_LEN   = 9;
    localparam int CNT_W     = $clog2(WIN_LEN + 1);
    localparam int TAG_IDX_W = $clog2(NUM_TAGS);
    localparam int NUM_STYLES = 4;
    localparam int STYLE_CAPS = 3;

    // Tag text, right-justified: the first character sits in the highest used byte.
    localparam int TAG_LEN [NUM_TAGS] = '{5, 6, 5, 6, 5, 6, 8, 9};
    localparam logic [8*WIN_LEN-1:0] TAG_TEXT [NUM_TAGS] = '{
        "[[b]]", "[[/b]]", "[[i]]", "[[/i]]",
        "[[u]]", "[[/u]]", "[[caps]]", "[[/caps]]"
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } text_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_bold;
        logic       is_italic;
        logic       is_underline;
        logic       is_caps;
        logic       last_of_item;
    } glyph_word_t;

    typedef struct packed {
        logic                 hit;
        logic [TAG_IDX_W-1:0] idx;
        logic                 prefix;
    } class_t;

    typedef struct packed {
        logic load;
        logic apply;
        logic release_byte;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic prefix;
        logic eot;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Compare the first n held bytes against every tag.
    function automatic class_t classify(input logic [WIN_LEN-1:0][7:0] win,
                                        input logic [CNT_W-1:0] n);
        class_t     r;
        logic       match;
        logic [7:0] ch;
        r = '0;
        for (int k = 0; k < NUM_TAGS; k++)
        begin
            match = (n <= CNT_W'(TAG_LEN[k]));
            for (int i = 0; i < WIN_LEN; i++)
            begin
                ch = 8'h00;
                if (i < TAG_LEN[k])
                begin
                    ch = 8'(TAG_TEXT[k] >> (8 * (TAG_LEN[k] - 1 - i)));
                end
                if ((CNT_W'(i) < n) && (win[i] != ch))
                begin
                    match = 1'b0;
                end
            end
            if (match)
            begin
                if (n == CNT_W'(TAG_LEN[k]))
                begin
                    if (!r.hit)
                    begin
                        r.hit = 1'b1;
                        r.idx = TAG_IDX_W'(k);
                    end
                end
                else
                begin
                    r.prefix = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/sts_ctrl.sv =====
// Controller state machine: accepts a word, then scans the window until it settles.
module sts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_stall,
    input  sts_pkg::dp_stat_t stat,
    output sts_pkg::dp_cmd_t  cmd
);

    sts_pkg::state_t state_reg;
    sts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        text_stall = 1'b1;
        case (state_reg)
            sts_pkg::ST_IDLE:
            begin
                text_stall = 1'b0;
                if (text_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts_pkg::ST_SCAN;
                end
            end
            sts_pkg::ST_SCAN:
            begin
                if (stat.empty)
                begin
                    state_next = sts_pkg::ST_IDLE;
                end
                else if (stat.hit)
                begin
                    cmd.apply  = 1'b1;
                    state_next = sts_pkg::ST_IDLE;
                end
                else if (stat.prefix && !stat.eot)
                begin
                    state_next = sts_pkg::ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    // release the first held byte; rescan the rest next cycle
                    cmd.release_byte = 1'b1;
                end
            end
            default:
            begin
                state_next = sts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sts_datapath.sv =====
// Datapath: held-byte window, style depth counters, classifier and output register.
module sts_datapath #(
    parameter int DEPTH_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sts_pkg::text_word_t  text_word,
    input  sts_pkg::dp_cmd_t     cmd,
    output sts_pkg::dp_stat_t    stat,
    output sts_pkg::glyph_word_t glyph_word,
    output logic                 glyph_valid,
    input  logic                 glyph_stall
);

    logic [sts_pkg::WIN_LEN-1:0][7:0] win_reg;
    logic [sts_pkg::WIN_LEN-1:0][7:0] win_next;
    logic [sts_pkg::WIN_LEN-1:0][7:0] win_shift;
    logic [sts_pkg::CNT_W-1:0]        count_reg;
    logic [sts_pkg::CNT_W-1:0]        count_next;
    logic [sts_pkg::CNT_W-1:0]        count_m1;
    logic                             eot_reg;
    logic                             eot_next;
    logic [DEPTH_BITS-1:0]            depth_reg  [sts_pkg::NUM_STYLES];
    logic [DEPTH_BITS-1:0]            depth_next [sts_pkg::NUM_STYLES];
    logic [sts_pkg::NUM_STYLES-1:0]   style_on;
    sts_pkg::glyph_word_t             out_reg;
    sts_pkg::glyph_word_t             out_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    sts_pkg::class_t                  cls_now;
    sts_pkg::class_t                  cls_rest;
    logic [1:0]                       style_sel;
    logic [7:0]                       ch;

    assign win_shift = win_reg >> 8;
    assign count_m1  = count_reg - sts_pkg::CNT_W'(1);
    assign cls_now   = sts_pkg::classify(win_reg, count_reg);
    assign cls_rest  = sts_pkg::classify(win_shift, count_m1);
    assign style_sel = cls_now.idx[sts_pkg::TAG_IDX_W-1:1];

    always_comb
    begin
        for (int s = 0; s < sts_pkg::NUM_STYLES; s++)
        begin
            style_on[s] = (depth_reg[s] != '0);
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.hit      = cls_now.hit;
    assign stat.prefix   = cls_now.prefix;
    assign stat.eot      = eot_reg;
    assign stat.out_free = !out_valid_reg || !glyph_stall;

    always_comb
    begin
        win_next       = win_reg;
        count_next     = count_reg;
        eot_next       = eot_reg;
        depth_next     = depth_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && glyph_stall;
        ch             = win_reg[0];
        if (style_on[sts_pkg::STYLE_CAPS] && (ch inside {[8'h61:8'h7A]}))
        begin
            ch = ch - 8'h20;
        end

        if (cmd.load)
        begin
            win_next[count_reg] = text_word.in_byte;
            count_next          = count_reg + sts_pkg::CNT_W'(1);
            eot_next            = text_word.end_of_text;
        end

        if (cmd.apply)
        begin
            count_next = '0;
            if (!cls_now.idx[0])
            begin
                // opening tag: saturate at the top
                if (depth_reg[style_sel] != '1)
                begin
                    depth_next[style_sel] = depth_reg[style_sel] + DEPTH_BITS'(1);
                end
            end
            else if (depth_reg[style_sel] != '0)
            begin
                depth_next[style_sel] = depth_reg[style_sel] - DEPTH_BITS'(1);
            end
        end

        if (cmd.release_byte)
        begin
            win_next              = win_shift;
            count_next            = count_m1;
            out_valid_next        = 1'b1;
            out_next.out_char     = ch;
            out_next.is_bold      = style_on[0];
            out_next.is_italic    = style_on[1];
            out_next.is_underline = style_on[2];
            out_next.is_caps      = style_on[3];
            // last unless the remainder will release another byte
            out_next.last_of_item = (count_reg == sts_pkg::CNT_W'(1)) ||
                                    (!eot_reg && (cls_rest.hit || cls_rest.prefix));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            eot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < sts_pkg::NUM_STYLES; s++)
            begin
                depth_reg[s] <= '0;
            end
        end
        else
        begin
            count_reg     <= count_next;
            eot_reg       <= eot_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        out_reg <= out_next;
    end

    assign glyph_word  = out_reg;
    assign glyph_valid = out_valid_reg;

endmodule

// ===== rtl/style_tag_stripper.sv =====
// Top level of the style tag stripper: controller plus datapath.
//
// Input channel text_valid / text_stall / text_word carries one text byte and its
// end-of-text mark per word. Output channel glyph_valid / glyph_stall / glyph_word
// carries one literal character with its bold, italic, underline and caps flags and
// a mark on the last character caused by an input word.
// A word is taken in the idle state; the window is then scanned, releasing the
// oldest held character at each step, until it settles on an empty window, a
// complete tag or a tag prefix short of the end of text, so a byte that completes
// a tag or extends such a prefix releases no character. Characters appear in the
// output register in the cycle after their release step. While that register is
// free, the scan loop releases one character per cycle through that single register.
// text_stall stays high from the accepting edge until the scan settles.
// If glyph_stall holds the output register full, the scan waits and the
// input stays stalled; nothing is dropped.
// Reset clears the style depths, the held-byte count and the output valid flag;
// the controller resets to idle, so the block can accept a word straight out of reset.
module style_tag_stripper #(
    parameter int DEPTH_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  sts_pkg::text_word_t  text_word,
    output logic                 glyph_valid,
    input  logic                 glyph_stall,
    output sts_pkg::glyph_word_t glyph_word
);

    sts_pkg::dp_cmd_t  cmd;
    sts_pkg::dp_stat_t stat;

    sts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    sts_datapath #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_word   (text_word),
        .cmd         (cmd),
        .stat        (stat),
        .glyph_word  (glyph_word),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall)
    );

endmodule

// ===== tb/style_tag_stripper_checker.sv =====
// Checker for the style tag stripper: predicts glyph words from text words and compares them.
`timescale 1ns / 1ps

module style_tag_stripper_checker #(
    parameter int DEPTH_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    input  logic                 text_stall,
    input  sts_pkg::text_word_t  text_word,
    input  logic                 glyph_valid,
    input  logic                 glyph_stall,
    input  sts_pkg::glyph_word_t glyph_word,
    input  logic                 drain_done,
    output int                   fails,
    output int                   expected_left
);

    typedef enum int {
        STY_BOLD      = 0,
        STY_ITALIC    = 1,
        STY_UNDERLINE = 2,
        STY_CAPS      = 3
    } style_e;

    localparam int SCAN_NONE   = 0;
    localparam int SCAN_PREFIX = 1;
    localparam int SCAN_TAG    = 2;
    localparam int HOLD_MAX    = 8;

    // Even entries open a style, odd entries close it; entry k belongs to style k/2.
    string tag_text [0:7] = '{
        "[[b]]", "[[/b]]", "[[i]]", "[[/i]]",
        "[[u]]", "[[/u]]", "[[caps]]", "[[/caps]]"
    };

    logic [7:0]            held [0:HOLD_MAX];
    int                    held_n;
    logic [DEPTH_BITS-1:0] style_depth [0:3];
    sts_pkg::glyph_word_t  glyph_q [$];
    sts_pkg::glyph_word_t  step_glyphs [$];
    int                    glyphs_checked;
    bit                    drain_seen;

    task automatic report(string what, int got, int want);
        $display("mismatch at glyph %0d: %s got %0h, expected %0h",
                 glyphs_checked, what, got, want);
        fails++;
    endtask

    task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report(what, int'(got), int'(want));
    endtask

    function automatic int scan_window();
        int  verdict;
        bit  same;
        verdict = SCAN_NONE;
        for (int k = 0; k < 8; k++)
        begin
            if (held_n > tag_text[k].len())
                continue;
            same = 1'b1;
            for (int i = 0; i < held_n; i++)
            begin
                if (held[i] != tag_text[k][i])
                    same = 1'b0;
            end
            if (!same)
                continue;
            if (held_n == tag_text[k].len())
                return SCAN_TAG + k;
            verdict = SCAN_PREFIX;
        end
        return verdict;
    endfunction

    function automatic void apply_tag(int k);
        style_e s;
        s = style_e'(k >> 1);
        if ((k & 1) == 0)
        begin
            // saturate at the top of the depth range
            if (style_depth[s] != '1)
                style_depth[s] = style_depth[s] + DEPTH_BITS'(1);
        end
        else
        begin
            if (style_depth[s] != '0)
                style_depth[s] = style_depth[s] - DEPTH_BITS'(1);
        end
    endfunction

    function automatic void release_oldest();
        sts_pkg::glyph_word_t g;
        logic [7:0]           ch;
        ch = held[0];
        if (style_depth[STY_CAPS] != '0 && ch >= "a" && ch <= "z")
            ch = ch - 8'h20;
        g.out_char     = ch;
        g.is_bold      = (style_depth[STY_BOLD] != '0);
        g.is_italic    = (style_depth[STY_ITALIC] != '0);
        g.is_underline = (style_depth[STY_UNDERLINE] != '0);
        g.is_caps      = (style_depth[STY_CAPS] != '0);
        g.last_of_item = 1'b0;
        step_glyphs = {step_glyphs, g};
        for (int i = 0; i < held_n - 1; i++)
            held[i] = held[i + 1];
        held_n--;
    endfunction

    function automatic void predict_glyphs(sts_pkg::text_word_t w);
        sts_pkg::glyph_word_t g;
        int                   verdict;
        step_glyphs.delete();
        if (held_n > HOLD_MAX)
            held_n = HOLD_MAX;
        held[held_n] = w.in_byte;
        held_n++;
        while (held_n > 0)
        begin
            verdict = scan_window();
            if (verdict >= SCAN_TAG)
            begin
                apply_tag(verdict - SCAN_TAG);
                held_n = 0;
            end
            else if (verdict == SCAN_PREFIX)
                break;
            else
                release_oldest();
        end
        // flush whatever is still held at the end of the text
        if (w.end_of_text)
        begin
            while (held_n > 0)
                release_oldest();
        end
        for (int i = 0; i < step_glyphs.size(); i++)
        begin
            g = step_glyphs[i];
            g.last_of_item = (i == step_glyphs.size() - 1);
            glyph_q = {glyph_q, g};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_n = 0;
            for (int s = 0; s < 4; s++)
                style_depth[s] = '0;
            glyph_q.delete();
            glyphs_checked = 0;
            drain_seen = 1'b0;
            fails = 0;
            expected_left <= 0;
        end
        else
        begin
            if (glyph_valid && !glyph_stall)
            begin
                if (glyph_q.size() == 0)
                    report("unexpected word, out_char", int'(glyph_word.out_char), 0);
                else
                begin
                    check_field("out_char", glyph_word.out_char, glyph_q[0].out_char);
                    check_field("is_bold", 8'(glyph_word.is_bold), 8'(glyph_q[0].is_bold));
                    check_field("is_italic", 8'(glyph_word.is_italic),
                                8'(glyph_q[0].is_italic));
                    check_field("is_underline", 8'(glyph_word.is_underline),
                                8'(glyph_q[0].is_underline));
                    check_field("is_caps", 8'(glyph_word.is_caps), 8'(glyph_q[0].is_caps));
                    check_field("last_of_item", 8'(glyph_word.last_of_item),
                                8'(glyph_q[0].last_of_item));
                    void'(glyph_q.pop_front());
                end
                glyphs_checked++;
            end
            if (text_valid && !text_stall)
                predict_glyphs(text_word);
            if (drain_done && !drain_seen)
            begin
                drain_seen = 1'b1;
                if (glyph_q.size() != 0)
                    report("words never delivered, count", glyph_q.size(), 0);
            end
            expected_left <= glyph_q.size();
        end
    end

endmodule

// ===== tb/style_tag_stripper_tb.sv =====
// Testbench top for the style tag stripper: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module style_tag_stripper_tb;

    // narrow depths so that saturation is reached by ordinary text
    localparam int DEPTH_BITS    = 2;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 300;
    localparam int SEGMENT_WORDS = 62;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 text_valid = 1'b0;
    logic                 text_stall;
    sts_pkg::text_word_t  text_word = '0;
    logic                 glyph_valid;
    logic                 glyph_stall = 1'b0;
    sts_pkg::glyph_word_t glyph_word;
    logic                 drain_done = 1'b0;
    int                   fails;
    int                   expected_left;

    sts_pkg::text_word_t  text_q [$];
    bit                   no_idle = 1'b0;
    int                   hold_len = 0;
    int                   words_sent = 0;
    int                   glyphs_taken = 0;
    int                   quiet_cycles = 0;

    string tag_src [0:7] = '{
        "[[b]]", "[[/b]]", "[[i]]", "[[/i]]",
        "[[u]]", "[[/u]]", "[[caps]]", "[[/caps]]"
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    style_tag_stripper #(
        .DEPTH_BITS (DEPTH_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_word   (text_word),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph_word  (glyph_word)
    );

    style_tag_stripper_checker #(
        .DEPTH_BITS (DEPTH_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_word     (text_word),
        .glyph_valid   (glyph_valid),
        .glyph_stall   (glyph_stall),
        .glyph_word    (glyph_word),
        .drain_done    (drain_done),
        .fails         (fails),
        .expected_left (expected_left)
    );

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [7:0] rand_char();
        string punct;
        punct = "[]/bicaps";
        case ($urandom_range(0, 3))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return 8'($urandom_range(0, 255));
            default: return punct[$urandom_range(0, punct.len() - 1)];
        endcase
    endfunction

    task automatic add_byte(logic [7:0] b, bit eot);
        sts_pkg::text_word_t w;
        w.in_byte     = b;
        w.end_of_text = eot;
        text_q = {text_q, w};
    endtask

    task automatic add_text(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    // Mostly whole tags and plain text, with broken tags and stray ends of text mixed in.
    task automatic make_random(int count);
        int k;
        int cut;
        int n;
        int pick;
        bit eot;
        while (text_q.size() < count)
        begin
            pick = $urandom_range(0, 9);
            eot  = ($urandom_range(0, 7) == 0);
            k    = $urandom_range(0, 7);
            if (pick <= 3)
                add_text(tag_src[k], eot);
            else if (pick <= 5)
            begin
                cut = $urandom_range(1, tag_src[k].len() - 1);
                add_text(tag_src[k].substr(0, cut - 1), eot && (pick == 5));
                if (pick == 4)
                    add_byte(rand_char(), eot);
            end
            else if (pick <= 8)
            begin
                n = $urandom_range(1, 4);
                repeat (n - 1) add_byte(rand_char(), 1'b0);
                add_byte(rand_char(), eot);
            end
            else
                add_byte(rand_char(), 1'b1);
        end
    endtask

    task automatic send_word(sts_pkg::text_word_t w);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_word  <= w;
        do @(posedge clk); while (text_stall);
        words_sent++;
    endtask

    task automatic send_queue();
        for (int i = 0; i < text_q.size(); i++)
        begin
            // switch between idling and back-to-back stretches now and then
            if (words_sent % 25 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_word(text_q[i]);
        end
        text_q.delete();
    endtask

    // Hold the input until every predicted word is out and the scan has settled.
    task automatic settle();
        text_valid <= 1'b0;
        // let the checker count the last accepted word first
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int w;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever
        begin
            w = draw_gap();
            if (hold_len > 0)
            begin
                w = hold_len;
                hold_len = 0;
            end
            if (w > 0)
            begin
                glyph_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            glyph_stall <= 1'b0;
            do @(posedge clk); while (!glyph_valid);
            glyphs_taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((text_valid && !text_stall) || (glyph_valid && !glyph_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // caps on lower-case boundaries, byte extremes, a nine-byte release, end on a held byte
        add_text("[[caps]]az`{", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_text("[[/caps]q", 1'b0);
        add_byte("[", 1'b1);
        send_queue();
        settle();

        make_random(SEGMENT_WORDS);
        send_queue();
        settle();

        // stall the output for a long stretch while text keeps coming
        hold_len = LONG_HOLD;
        make_random(SEGMENT_WORDS);
        send_queue();
        settle();

        make_random(SEGMENT_WORDS);
        send_queue();
        settle();

        drain_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("run covered %0d text words and %0d glyph words, with random gaps,",
                 words_sent, glyphs_taken);
        $display("back-to-back stretches, a long output hold-off and saturating depths");
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sts_pkg.sv
rtl/sts_ctrl.sv
rtl/sts_datapath.sv
rtl/style_tag_stripper.sv
tb/style_tag_stripper_checker.sv
tb/style_tag_stripper_tb.sv
